FILE: rtl/tet_pkg.sv
package tet_pkg;

  localparam int DIFF_W    = 16;
  localparam int D_W       = 18;
  localparam int M_W       = 20;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RISE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd3;

  localparam logic [CFG_W-1:0] RISE_DEFAULT   = 8'd15;
  localparam logic [CFG_W-1:0] DROP_DEFAULT   = 8'd25;
  localparam logic [CFG_W-1:0] WINDOW_DEFAULT = 8'd5;
  localparam logic [CFG_W-1:0] OFFSET_DEFAULT = 8'd0;

  typedef struct packed {
    logic                    active;
    logic                    init;
    logic                    finger_ok;
    logic [DIFF_W-1:0]       diff;
    logic signed [D_W-1:0]   d;
    logic [DIFF_W-1:0]       rise_delta;
    logic [DIFF_W-1:0]       fall_delta;
  } front_item_t;

  typedef struct packed {
    logic              pressed;
    logic [DIFF_W-1:0] diff_echo;
    logic [DIFF_W-1:0] env_high;
    logic [DIFF_W-1:0] env_low;
    logic [DIFF_W-1:0] margin;
  } result_t;

endpackage

FILE: rtl/touch_envelope_trigger.sv
// channel   direction  handshake              fields
// input     in         push / full            chan_active, diff_count, baseline_count,
//                                             noise_thresh, neg_noise_thresh,
//                                             finger_thresh, time_ms
// result    out        empty / pop            pressed, diff_echo, env_high, env_low, margin
// config    in         cfg_write, cfg_index   cfg_data
//
// One item per cycle sustained while full is low and the result queue has room; a
// result passes the front stages for the per mille deltas (products, quotient estimates,
// exact quotients), the mid queue, then the back step that writes the 2-entry result queue.
// full rises while 8 accepted items wait for the back; the back holds while 2
// results wait. Reset loads 15, 25, 5, 0 into the registers, clears the
// envelope state and empties both queues.
module touch_envelope_trigger import tet_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 chan_active,
  input  logic [DIFF_W-1:0]    diff_count,
  input  logic [DIFF_W-1:0]    baseline_count,
  input  logic [DIFF_W-1:0]    noise_thresh,
  input  logic [DIFF_W-1:0]    neg_noise_thresh,
  input  logic [DIFF_W-1:0]    finger_thresh,
  input  logic [31:0]          time_ms,
  output logic                 empty,
  input  logic                 pop,
  output logic                 pressed,
  output logic [DIFF_W-1:0]    diff_echo,
  output logic [DIFF_W-1:0]    env_high,
  output logic [DIFF_W-1:0]    env_low,
  output logic [DIFF_W-1:0]    margin,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int MQ_DEPTH = 8;
  localparam int OQ_DEPTH = 2;
  localparam int CW       = $clog2(MQ_DEPTH + 1);
  localparam int MQ_W     = $bits(front_item_t) + TIME_WIDTH;

  logic [CFG_W-1:0] release_pm;
  logic [CFG_W-1:0] repress_pm;
  logic [CFG_W-1:0] hold_win;
  logic [CFG_W-1:0] baseline_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_pm      <= RISE_DEFAULT;
      repress_pm      <= DROP_DEFAULT;
      hold_win        <= WINDOW_DEFAULT;
      baseline_offset <= OFFSET_DEFAULT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RISE:   release_pm      <= cfg_data;
        REG_DROP:   repress_pm      <= cfg_data;
        REG_WINDOW: hold_win        <= cfg_data;
        REG_OFFSET: baseline_offset <= cfg_data;
        default:    release_pm      <= release_pm;
      endcase
    end
  end

  logic [CFG_W-1:0] rise_eff;
  logic [CFG_W-1:0] drop_eff;
  logic [CFG_W-1:0] win_eff;

  assign rise_eff = (release_pm == '0) ? RISE_DEFAULT : release_pm;
  assign drop_eff = (repress_pm == '0) ? DROP_DEFAULT : repress_pm;
  assign win_eff  = (hold_win == '0) ? WINDOW_DEFAULT : hold_win;

  // items in flight between accept and back take; bounds the mid queue
  logic [CW-1:0] inflight;
  logic          accept;
  logic          mid_pop;

  assign accept = push && !full;
  assign full   = (inflight == CW'(MQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (accept && !mid_pop) begin
      inflight <= inflight + CW'(1);
    end else if (mid_pop && !accept) begin
      inflight <= inflight - CW'(1);
    end
  end

  logic                  front_valid;
  front_item_t           front_item;
  logic [TIME_WIDTH-1:0] front_now;

  tet_front #(
    .TW(TIME_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (accept),
    .chan_active      (chan_active),
    .diff_count       (diff_count),
    .baseline_count   (baseline_count),
    .noise_thresh     (noise_thresh),
    .neg_noise_thresh (neg_noise_thresh),
    .finger_thresh    (finger_thresh),
    .now              (time_ms[TIME_WIDTH-1:0]),
    .rise_pm          (rise_eff),
    .drop_pm          (drop_eff),
    .offset           (baseline_offset),
    .out_valid        (front_valid),
    .out_item         (front_item),
    .out_now          (front_now)
  );

  logic [MQ_W-1:0]       mid_rdata;
  logic                  mid_full;
  logic                  mid_empty;
  front_item_t           back_item;
  logic [TIME_WIDTH-1:0] back_now;

  tet_fifo #(
    .WIDTH(MQ_W),
    .DEPTH(MQ_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (front_valid),
    .wdata ({front_item, front_now}),
    .rd    (mid_pop),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty)
  );

  assign back_item = mid_rdata[MQ_W-1:TIME_WIDTH];
  assign back_now  = mid_rdata[TIME_WIDTH-1:0];

  logic    out_full;
  result_t back_res;
  result_t out_res;

  tet_back #(
    .TW(TIME_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!mid_empty),
    .item       (back_item),
    .now        (back_now),
    .win        (win_eff),
    .item_take  (mid_pop),
    .res_ready  (!out_full),
    .res        (back_res)
  );

  tet_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (mid_pop),
    .wdata (back_res),
    .rd    (pop),
    .rdata (out_res),
    .full  (out_full),
    .empty (empty)
  );

  assign pressed   = out_res.pressed;
  assign diff_echo = out_res.diff_echo;
  assign env_high  = out_res.env_high;
  assign env_low   = out_res.env_low;
  assign margin    = out_res.margin;

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    front_valid |-> !mid_full)
    else $error("mid queue written while full");

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(MQ_DEPTH))
    else $error("in-flight count above queue depth");

  a_inflight_count: assert property (@(posedge clk) disable iff (rst)
    (accept && !mid_pop) |=> (inflight == $past(inflight) + CW'(1)))
    else $error("in-flight count missed an accepted item");

endmodule

FILE: rtl/tet_fifo.sv
module tet_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/tet_front.sv
module tet_front import tet_pkg::*; #(
  parameter int TW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              chan_active,
  input  logic [DIFF_W-1:0] diff_count,
  input  logic [DIFF_W-1:0] baseline_count,
  input  logic [DIFF_W-1:0] noise_thresh,
  input  logic [DIFF_W-1:0] neg_noise_thresh,
  input  logic [DIFF_W-1:0] finger_thresh,
  input  logic [TW-1:0]     now,
  input  logic [CFG_W-1:0]  rise_pm,
  input  logic [CFG_W-1:0]  drop_pm,
  input  logic [CFG_W-1:0]  offset,
  output logic              out_valid,
  output front_item_t       out_item,
  output logic [TW-1:0]     out_now
);

  localparam int PROD_W      = DIFF_W + CFG_W;
  localparam int RECIP_W     = 25;
  localparam int EST_W       = PROD_W + RECIP_W;
  localparam int RECIP_SHIFT = 34;
  localparam int Q_W         = 15;
  localparam int SUM_W       = DIFF_W + 1;
  localparam logic [RECIP_W-1:0] RECIP   = 25'd17179869;
  localparam logic [PROD_W:0]    DIVISOR = 25'd1000;

  typedef struct packed {
    logic                  active;
    logic                  init;
    logic                  finger_ok;
    logic [DIFF_W-1:0]     diff;
    logic signed [D_W-1:0] d;
    logic [DIFF_W-1:0]     nz;
    logic [TW-1:0]         now;
  } carry_t;

  function automatic logic [DIFF_W-1:0] median3(input logic [DIFF_W-1:0] a,
                                                 input logic [DIFF_W-1:0] b,
                                                 input logic [DIFF_W-1:0] c);
    logic [DIFF_W-1:0] lo;
    logic [DIFF_W-1:0] hi;
    logic [DIFF_W-1:0] mid;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (hi < c) ? hi : c;
    return (lo > mid) ? lo : mid;
  endfunction

  // sample history: valid only between first active and next inactive sample
  logic              hvalid;
  logic [DIFF_W-1:0] hist0;
  logic [DIFF_W-1:0] hist1;

  logic [DIFF_W-1:0]     med;
  logic signed [D_W-1:0] d_in;
  carry_t                c_in;
  logic [PROD_W-1:0]     pr_in;
  logic [PROD_W-1:0]     pd_in;

  assign med  = hvalid ? median3(diff_count, hist0, hist1) : diff_count;
  assign d_in = $signed({{(D_W-DIFF_W){1'b0}}, med})
              + $signed({{(D_W-CFG_W){offset[CFG_W-1]}}, offset});
  assign pr_in = PROD_W'(baseline_count) * PROD_W'(rise_pm);
  assign pd_in = PROD_W'(baseline_count) * PROD_W'(drop_pm);

  always_comb begin
    c_in.active    = chan_active;
    c_in.init      = !hvalid;
    c_in.finger_ok = d_in[DIFF_W-1:0] > finger_thresh;
    c_in.diff      = diff_count;
    c_in.d         = d_in;
    c_in.nz        = (noise_thresh > neg_noise_thresh) ? noise_thresh : neg_noise_thresh;
    c_in.now       = now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= 1'b0;
    end else if (in_valid) begin
      hvalid <= chan_active;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && chan_active) begin
      hist0 <= diff_count;
      hist1 <= hvalid ? hist0 : diff_count;
    end
  end

  // stage 1: products
  logic              s1_valid;
  carry_t            s1;
  logic [PROD_W-1:0] s1_pr;
  logic [PROD_W-1:0] s1_pd;

  // stage 2: quotient estimates by reciprocal
  logic              s2_valid;
  carry_t            s2;
  logic [PROD_W-1:0] s2_pr;
  logic [PROD_W-1:0] s2_pd;
  logic [Q_W-1:0]    s2_qr;
  logic [Q_W-1:0]    s2_qd;
  logic [EST_W-1:0]  est_r;
  logic [EST_W-1:0]  est_d;

  assign est_r = EST_W'(s1_pr) * EST_W'(RECIP);
  assign est_d = EST_W'(s1_pd) * EST_W'(RECIP);

  // stage 3: exact quotients
  logic              s3_valid;
  carry_t            s3;
  logic [Q_W-1:0]    s3_qr;
  logic [Q_W-1:0]    s3_qd;
  logic [PROD_W:0]   rem_r;
  logic [PROD_W:0]   rem_d;

  assign rem_r = {1'b0, s2_pr} - ((PROD_W + 1)'(s2_qr) * DIVISOR);
  assign rem_d = {1'b0, s2_pd} - ((PROD_W + 1)'(s2_qd) * DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1    <= c_in;
    s1_pr <= pr_in;
    s1_pd <= pd_in;
    s2    <= s1;
    s2_pr <= s1_pr;
    s2_pd <= s1_pd;
    s2_qr <= est_r[RECIP_SHIFT +: Q_W];
    s2_qd <= est_d[RECIP_SHIFT +: Q_W];
    s3    <= s2;
    s3_qr <= (rem_r >= DIVISOR) ? s2_qr + Q_W'(1) : s2_qr;
    s3_qd <= (rem_d >= DIVISOR) ? s2_qd + Q_W'(1) : s2_qd;
  end

  // stage 4: add noise threshold and saturate
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_d;

  assign sum_r = SUM_W'(s3_qr) + SUM_W'(s3.nz);
  assign sum_d = SUM_W'(s3_qd) + SUM_W'(s3.nz);

  assign out_valid = s3_valid;
  assign out_now   = s3.now;

  always_comb begin
    out_item.active     = s3.active;
    out_item.init       = s3.init;
    out_item.finger_ok  = s3.finger_ok;
    out_item.diff       = s3.diff;
    out_item.d          = s3.d;
    out_item.rise_delta = sum_r[DIFF_W] ? '1 : sum_r[DIFF_W-1:0];
    out_item.fall_delta = sum_d[DIFF_W] ? '1 : sum_d[DIFF_W-1:0];
  end

endmodule

FILE: rtl/tet_back.sv
module tet_back import tet_pkg::*; #(
  parameter int TW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  front_item_t      item,
  input  logic [TW-1:0]    now,
  input  logic [CFG_W-1:0] win,
  output logic             item_take,
  input  logic             res_ready,
  output result_t          res
);

  function automatic logic [DIFF_W-1:0] sat16(input logic signed [M_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (|v[M_W-2:DIFF_W]) begin
      return '1;
    end
    return v[DIFF_W-1:0];
  endfunction

  function automatic logic signed [M_W-1:0] ext(input logic signed [D_W-1:0] v);
    return $signed({{(M_W-D_W){v[D_W-1]}}, v});
  endfunction

  logic [DIFF_W-1:0]     rise_delta;
  logic [DIFF_W-1:0]     fall_delta;
  logic signed [D_W-1:0] peak_value;
  logic signed [D_W-1:0] trough_value;
  logic [TW-1:0]         peak_time;
  logic [TW-1:0]         trough_time;
  logic                  released;
  logic                  env_valid;

  logic [DIFF_W-1:0]     rd;
  logic [DIFF_W-1:0]     fd;
  logic [TW-1:0]         pt0;
  logic [TW-1:0]         tt0;
  logic                  rel0;
  logic                  ev0;
  logic                  p_exp;
  logic                  t_exp;
  logic                  pk_upd;
  logic                  tr_upd;
  logic signed [D_W-1:0] pk_a;
  logic signed [D_W-1:0] tr_a;
  logic [TW-1:0]         pt_a;
  logic [TW-1:0]         tt_a;
  logic signed [M_W-1:0] rise_gap;
  logic signed [M_W-1:0] fall_gap;
  logic                  repress;
  logic                  release_hit;

  logic signed [D_W-1:0] peak_next;
  logic signed [D_W-1:0] trough_next;
  logic [TW-1:0]         peak_time_next;
  logic [TW-1:0]         trough_time_next;
  logic                  released_next;
  logic signed [M_W-1:0] m;

  assign item_take = item_valid && res_ready;

  always_comb begin
    rd   = item.init ? item.rise_delta : rise_delta;
    fd   = item.init ? item.fall_delta : fall_delta;
    pt0  = item.init ? now : peak_time;
    tt0  = item.init ? now : trough_time;
    rel0 = item.init ? 1'b0 : released;
    ev0  = item.init ? 1'b0 : env_valid;

    p_exp  = (now - pt0) > TW'(win);
    t_exp  = (now - tt0) > TW'(win);
    pk_upd = !ev0 || p_exp || (item.d > peak_value);
    tr_upd = !ev0 || t_exp || (item.d < trough_value);
    pk_a   = pk_upd ? item.d : peak_value;
    pt_a   = pk_upd ? now : pt0;
    tr_a   = tr_upd ? item.d : trough_value;
    tt_a   = tr_upd ? now : tt0;

    fall_gap    = ext(item.d) - ext(tr_a);
    rise_gap    = ext(pk_a) - ext(item.d);
    repress     = (fall_gap > $signed({{(M_W-DIFF_W){1'b0}}, fd})) && item.finger_ok;
    release_hit = rise_gap > $signed({{(M_W-DIFF_W){1'b0}}, rd});

    if (rel0) begin
      if (repress) begin
        peak_next        = item.d;
        trough_next      = item.d;
        peak_time_next   = now;
        trough_time_next = now;
        released_next    = 1'b0;
      end else begin
        peak_next        = peak_value;
        trough_next      = tr_a;
        peak_time_next   = pt0;
        trough_time_next = tt_a;
        released_next    = 1'b1;
      end
    end else begin
      if (release_hit) begin
        peak_next        = item.d;
        trough_next      = item.d;
        peak_time_next   = now;
        trough_time_next = now;
        released_next    = 1'b1;
      end else begin
        peak_next        = pk_a;
        trough_next      = tr_a;
        peak_time_next   = pt_a;
        trough_time_next = tt_a;
        released_next    = 1'b0;
      end
    end

    m = released_next ? ext(item.d) - ext(trough_next) : ext(peak_next) - ext(item.d);

    res.diff_echo = item.diff;
    res.pressed   = item.active && !released_next;
    res.env_high  = item.active ? sat16(ext(peak_next)) : '0;
    res.env_low   = item.active ? sat16(ext(trough_next)) : '0;
    res.margin    = item.active ? sat16(m) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_delta   <= '0;
      fall_delta   <= '0;
      peak_value   <= '0;
      trough_value <= '0;
      peak_time    <= '0;
      trough_time  <= '0;
      released     <= 1'b0;
      env_valid    <= 1'b0;
    end else if (item_take) begin
      if (!item.active) begin
        released <= 1'b0;
      end else begin
        rise_delta   <= rd;
        fall_delta   <= fd;
        peak_value   <= peak_next;
        trough_value <= trough_next;
        peak_time    <= peak_time_next;
        trough_time  <= trough_time_next;
        released     <= released_next;
        env_valid    <= 1'b1;
      end
    end
  end

endmodule
